// ===== rtl/tdcs_pkg.sv =====
// Package: shared constants, codes and types of the distinct-value grouping core
`timescale 1ns / 1ps
`default_nettype none
package tdcs_pkg;
    localparam int VAL_W           = 32;
    localparam int CNT_W           = 7;
    localparam int TOL_W           = 31;
    localparam int OFS_W           = 16;
    localparam int NODE_W          = 17;
    localparam int CFG_IDX_W       = 1;
    localparam int CFG_DATA_W      = 32;
    localparam int DEF_MAX_OBJECTS = 64;

    localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_INDEX_OFFSET = 1'b1;

    // operation broadcast to every cell
    typedef enum logic [2:0] {
        CELL_NOP,
        CELL_INTAKE,
        CELL_LOAD_R,
        CELL_RANK,
        CELL_LOAD_S,
        CELL_SORT,
        CELL_SHIFT_OUT,
        CELL_CLEAR
    } t_cell_op;

    typedef struct packed {
        t_cell_op                 op;
        logic signed [VAL_W-1:0]  sample;
        logic        [TOL_W-1:0]  tol;
    } t_cell_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD_R,
        S_RANK,
        S_LOAD_S,
        S_SORT,
        S_RD_G,
        S_RD_R,
        S_OUT
    } t_state;
endpackage
`default_nettype wire

// ===== rtl/tdcs_if.sv =====
// Interfaces: sample input, result output and configuration write channels
`timescale 1ns / 1ps
`default_nettype none
interface tdcs_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] sample;
    logic               last_sample;
    modport source (output valid, sample, last_sample, input ready);
    modport sink   (input valid, sample, last_sample, output ready);
endinterface

interface tdcs_out_if;
    logic               valid;
    logic               ready;
    logic        [16:0] object_node;
    logic signed [31:0] node_value;
    logic        [6:0]  node_count;
    logic               node_valid;
    logic               overflow;
    logic               last_result;
    modport source (output valid, object_node, node_value, node_count, node_valid,
                    overflow, last_result, input ready);
    modport sink   (input valid, object_node, node_value, node_count, node_valid,
                    overflow, last_result, output ready);
endinterface

interface tdcs_cfg_if;
    logic        valid;
    logic        ready;
    logic [0:0]  index;
    logic [31:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/tdcs_ram.sv =====
// Generic single-write, single-read RAM with registered read
`timescale 1ns / 1ps
`default_nettype none
module tdcs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire [$clog2(DEPTH)-1:0]  i_waddr,
    input  wire [WIDTH-1:0]          i_wdata,
    input  wire                      i_re,
    input  wire [$clog2(DEPTH)-1:0]  i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

// ===== rtl/tdcs_cell.sv =====
// One cell: holds a distinct value, its count, its rank and ring/sort stages
`timescale 1ns / 1ps
`default_nettype none
module tdcs_cell
    import tdcs_pkg::*;
#(
    parameter int IW     = 6,
    parameter int MY_IDX = 0
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  t_cell_cmd               i_cmd,
    input  wire                     i_hit,
    input  wire                     i_new,
    input  wire signed [VAL_W-1:0]  i_pass_val,
    input  wire [CNT_W-1:0]         i_pass_cnt,
    input  wire [IW-1:0]            i_pass_rank,
    input  wire [IW-1:0]            i_pass_idx,
    input  wire                     i_pass_ok,
    input  wire signed [VAL_W-1:0]  i_sort_val,
    input  wire [CNT_W-1:0]         i_sort_cnt,
    output logic                    o_match,
    output logic signed [VAL_W-1:0] o_pass_val,
    output logic [CNT_W-1:0]        o_pass_cnt,
    output logic [IW-1:0]           o_pass_rank,
    output logic [IW-1:0]           o_pass_idx,
    output logic                    o_pass_ok,
    output logic signed [VAL_W-1:0] o_sort_val,
    output logic [CNT_W-1:0]        o_sort_cnt
);
    localparam logic [IW-1:0] MY = IW'(MY_IDX);

    logic                    r_valid;
    logic signed [VAL_W-1:0] r_val;
    logic [CNT_W-1:0]        r_cnt;
    logic [IW-1:0]           r_rank;
    logic signed [VAL_W:0]   w_diff;
    logic [VAL_W:0]          w_abs;
    logic                    w_before;

    // tolerance match against the broadcast sample, exact 33-bit difference
    always_comb begin
        w_diff  = {r_val[VAL_W-1], r_val} - {i_cmd.sample[VAL_W-1], i_cmd.sample};
        w_abs   = w_diff[VAL_W] ? (~w_diff + 1'b1) : w_diff;
        o_match = r_valid && (w_abs < {2'b00, i_cmd.tol});
    end

    // passing value sorts ahead of ours: smaller, or equal and older
    assign w_before = i_pass_ok &&
        ((i_pass_val < r_val) || ((i_pass_val == r_val) && (i_pass_idx < MY)));

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.op == CELL_CLEAR) begin
            r_valid <= 1'b0;
        end else if (i_cmd.op == CELL_INTAKE && i_new) begin
            r_valid <= 1'b1;
        end
    end

    // value, count, rank, ring stage and sorted stage
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            CELL_INTAKE: begin
                if (i_new) begin
                    r_val <= i_cmd.sample;
                    r_cnt <= CNT_W'(1);
                end else if (i_hit) begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
            CELL_LOAD_R, CELL_LOAD_S: begin
                o_pass_val  <= r_val;
                o_pass_cnt  <= r_cnt;
                o_pass_rank <= r_rank;
                o_pass_idx  <= MY;
                o_pass_ok   <= r_valid;
                if (i_cmd.op == CELL_LOAD_R) begin
                    r_rank <= '0;
                end
            end
            CELL_RANK: begin
                if (w_before) begin
                    r_rank <= r_rank + 1'b1;
                end
                o_pass_val  <= i_pass_val;
                o_pass_cnt  <= i_pass_cnt;
                o_pass_rank <= i_pass_rank;
                o_pass_idx  <= i_pass_idx;
                o_pass_ok   <= i_pass_ok;
            end
            CELL_SORT: begin
                if (o_pass_ok && o_pass_rank == MY) begin
                    o_sort_val <= o_pass_val;
                    o_sort_cnt <= o_pass_cnt;
                end
                o_pass_val  <= i_pass_val;
                o_pass_cnt  <= i_pass_cnt;
                o_pass_rank <= i_pass_rank;
                o_pass_idx  <= i_pass_idx;
                o_pass_ok   <= i_pass_ok;
            end
            CELL_SHIFT_OUT: begin
                o_sort_val <= i_sort_val;
                o_sort_cnt <= i_sort_cnt;
            end
            default: begin
            end
        endcase
    end
endmodule
`default_nettype wire

// ===== rtl/tolerant_distinct_count_sort_core.sv =====
// Top level: tolerant distinct-value grouping with ascending rank emission
// Usage:
//   i_cfg writes tolerance (index 0, unsigned Q15.16, strict compare) and
//   index_offset (index 1); always ready, write only while idle.
//   i_in carries one sample per item; last_sample closes the column.
//   Samples are taken one per cycle while idle: every cell compares in parallel;
//   the earliest matching cell wins through a one-hot priority pick.
//   After the last item the block ranks over a ring of MAX_OBJECTS cells:
//   a load step and a full ring turn for ranking, the same again for sorting,
//   with no input taken meanwhile.
//   Then one result per stored object leaves o_out, each after a group RAM
//   read followed by a rank RAM read.
//   A stalled receiver holds the output register; the block waits with it.
//   Once the final result is loaded the block takes samples again.
//   Samples past capacity are dropped and raise overflow on the run's results.
//   Reset clears counts, flags, state, configuration, output valid and cell valid bits.
`timescale 1ns / 1ps
`default_nettype none
module tolerant_distinct_count_sort_core
    import tdcs_pkg::*;
#(
    parameter int MAX_OBJECTS = DEF_MAX_OBJECTS
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    tdcs_cfg_if.sink    i_cfg,
    tdcs_in_if.sink     i_in,
    tdcs_out_if.source  o_out
);
    localparam int N  = MAX_OBJECTS;
    localparam int IW = $clog2(N);
    localparam logic [IW:0]   N_CNT = (IW+1)'(N);
    localparam logic [IW-1:0] N_M1  = IW'(N - 1);

    t_state            r_state, n_state;
    logic [TOL_W-1:0]  r_tol;
    logic [OFS_W-1:0]  r_ofs;
    logic [IW:0]       r_obj, r_dist;
    logic              r_drop;
    logic [IW-1:0]     r_cyc, r_k;
    t_cell_cmd         w_cmd;

    logic                    w_acc, w_full, w_hit_any, w_last_k;
    logic [N-1:0]            w_match, w_oh, w_hit, w_new;
    logic [IW-1:0]           w_enc;
    logic                    w_g_we, w_g_re, w_r_we, w_r_re;
    logic [IW-1:0]           w_g_rdata, w_r_rdata;

    logic signed [VAL_W-1:0] w_pass_val  [N];
    logic [CNT_W-1:0]        w_pass_cnt  [N];
    logic [IW-1:0]           w_pass_rank [N];
    logic [IW-1:0]           w_pass_idx  [N];
    logic                    w_pass_ok   [N];
    logic signed [VAL_W-1:0] w_sort_val  [N+1];
    logic [CNT_W-1:0]        w_sort_cnt  [N+1];

    // configuration port
    assign i_cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= '0;
            r_ofs <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_TOLERANCE:    r_tol <= i_cfg.data[TOL_W-1:0];
                REG_INDEX_OFFSET: r_ofs <= i_cfg.data[OFS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // intake: first matching cell wins
    assign i_in.ready = (r_state == S_IDLE);
    assign w_acc      = i_in.valid && i_in.ready;
    assign w_full     = (r_obj == N_CNT);
    assign w_hit_any  = |w_match;
    assign w_oh       = w_match & (~w_match + 1'b1);

    always_comb begin
        w_enc = '0;
        for (int b = 0; b < IW; b++) begin
            for (int i = 0; i < N; i++) begin
                if (((i >> b) & 1) == 1) begin
                    w_enc[b] = w_enc[b] | w_oh[i];
                end
            end
        end
    end

    always_comb begin
        w_new = '0;
        for (int i = 0; i < N; i++) begin
            w_new[i] = w_acc && !w_full && !w_hit_any && (r_dist[IW-1:0] == IW'(i));
        end
    end
    assign w_hit  = (w_acc && !w_full) ? w_oh : '0;
    assign w_g_we = w_acc && !w_full;

    assign w_last_k = ({1'b0, r_k} + 1'b1) == r_obj;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and cell commands
    always_comb begin
        n_state    = r_state;
        w_cmd.op   = CELL_NOP;
        w_cmd.sample = i_in.sample;
        w_cmd.tol    = r_tol;
        w_g_re     = 1'b0;
        w_r_re     = 1'b0;
        w_r_we     = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    w_cmd.op = CELL_INTAKE;
                    if (i_in.last_sample) begin
                        n_state = S_LOAD_R;
                    end
                end
            end
            S_LOAD_R: begin
                w_cmd.op = CELL_LOAD_R;
                n_state  = S_RANK;
            end
            S_RANK: begin
                w_cmd.op = CELL_RANK;
                if (r_cyc == N_M1) begin
                    n_state = S_LOAD_S;
                end
            end
            S_LOAD_S: begin
                w_cmd.op = CELL_LOAD_S;
                n_state  = S_SORT;
            end
            S_SORT: begin
                w_cmd.op = CELL_SORT;
                w_r_we   = w_pass_ok[0];
                if (r_cyc == N_M1) begin
                    n_state = S_RD_G;
                end
            end
            S_RD_G: begin
                w_g_re  = 1'b1;
                n_state = S_RD_R;
            end
            S_RD_R: begin
                w_r_re  = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!o_out.valid || o_out.ready) begin
                    if (w_last_k) begin
                        w_cmd.op = CELL_CLEAR;
                        n_state  = S_IDLE;
                    end else begin
                        w_cmd.op = CELL_SHIFT_OUT;
                        n_state  = S_RD_G;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // counters and run flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_obj  <= '0;
            r_dist <= '0;
            r_drop <= 1'b0;
            r_cyc  <= '0;
            r_k    <= '0;
        end else begin
            if (r_state == S_IDLE && w_acc) begin
                if (w_full) begin
                    r_drop <= 1'b1;
                end else begin
                    r_obj <= r_obj + 1'b1;
                    if (!w_hit_any) begin
                        r_dist <= r_dist + 1'b1;
                    end
                end
            end
            if (r_state == S_RANK || r_state == S_SORT) begin
                r_cyc <= (r_cyc == N_M1) ? '0 : r_cyc + 1'b1;
            end
            if (r_state == S_OUT && (!o_out.valid || o_out.ready)) begin
                if (w_last_k) begin
                    r_k    <= '0;
                    r_obj  <= '0;
                    r_dist <= '0;
                    r_drop <= 1'b0;
                end else begin
                    r_k <= r_k + 1'b1;
                end
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out.valid <= 1'b0;
        end else if (r_state == S_OUT && (!o_out.valid || o_out.ready)) begin
            o_out.valid <= 1'b1;
        end else if (o_out.ready) begin
            o_out.valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && (!o_out.valid || o_out.ready)) begin
            o_out.object_node <= NODE_W'(w_r_rdata) + NODE_W'(r_ofs);
            if ({1'b0, r_k} < r_dist) begin
                o_out.node_value <= w_sort_val[0];
                o_out.node_count <= w_sort_cnt[0];
                o_out.node_valid <= 1'b1;
            end else begin
                o_out.node_value <= '0;
                o_out.node_count <= '0;
                o_out.node_valid <= 1'b0;
            end
            o_out.overflow    <= r_drop;
            o_out.last_result <= w_last_k;
        end
    end

    // object group per stored sample, rank per distinct value
    tdcs_ram #(.WIDTH(IW), .DEPTH(N)) u_group_ram (
        .i_clk   (i_clk),
        .i_we    (w_g_we),
        .i_waddr (r_obj[IW-1:0]),
        .i_wdata (w_hit_any ? w_enc : r_dist[IW-1:0]),
        .i_re    (w_g_re),
        .i_raddr (r_k),
        .o_rdata (w_g_rdata)
    );

    tdcs_ram #(.WIDTH(IW), .DEPTH(N)) u_rank_ram (
        .i_clk   (i_clk),
        .i_we    (w_r_we),
        .i_waddr (w_pass_idx[0]),
        .i_wdata (w_pass_rank[0]),
        .i_re    (w_r_re),
        .i_raddr (w_g_rdata),
        .o_rdata (w_r_rdata)
    );

    // row of cells: ring moves toward higher index, sorted row drains to cell 0
    assign w_sort_val[N] = '0;
    assign w_sort_cnt[N] = '0;

    for (genvar g = 0; g < N; g++) begin : g_cell
        tdcs_cell #(.IW(IW), .MY_IDX(g)) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_cmd       (w_cmd),
            .i_hit       (w_hit[g]),
            .i_new       (w_new[g]),
            .i_pass_val  (w_pass_val[(g + N - 1) % N]),
            .i_pass_cnt  (w_pass_cnt[(g + N - 1) % N]),
            .i_pass_rank (w_pass_rank[(g + N - 1) % N]),
            .i_pass_idx  (w_pass_idx[(g + N - 1) % N]),
            .i_pass_ok   (w_pass_ok[(g + N - 1) % N]),
            .i_sort_val  (w_sort_val[g + 1]),
            .i_sort_cnt  (w_sort_cnt[g + 1]),
            .o_match     (w_match[g]),
            .o_pass_val  (w_pass_val[g]),
            .o_pass_cnt  (w_pass_cnt[g]),
            .o_pass_rank (w_pass_rank[g]),
            .o_pass_idx  (w_pass_idx[g]),
            .o_pass_ok   (w_pass_ok[g]),
            .o_sort_val  (w_sort_val[g]),
            .o_sort_cnt  (w_sort_cnt[g])
        );
    end

    // checks
    a_dist_le_obj: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dist <= r_obj) else $error("distinct count above object count");
    a_obj_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_obj <= N_CNT) else $error("object count above capacity");
    a_rank_to_sort: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RANK && r_cyc == N_M1) |=> (r_state == S_LOAD_S))
        else $error("rank pass did not end after a full ring turn");
    a_drop_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && w_full && !i_in.last_sample) |=> r_drop)
        else $error("dropped sample not flagged");
    a_no_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !w_acc) else $error("item taken while busy");
endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
// Testbench for the tolerant distinct-value grouping and sort core
`timescale 1ns / 1ps
module tb_top;
    import tdcs_pkg::*;

    localparam int CAPACITY    = DEF_MAX_OBJECTS;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int SETTLE      = 2 * CAPACITY + 20;

    typedef struct packed {
        logic        [NODE_W-1:0] node;
        logic signed [VAL_W-1:0]  value;
        logic        [CNT_W-1:0]  count;
        logic                     valid;
        logic                     ovf;
        logic                     last;
    } t_node_result;

    logic i_clk;
    logic i_rst_n;

    tdcs_cfg_if cfg_if ();
    tdcs_in_if  in_if ();
    tdcs_out_if out_if ();

    tolerant_distinct_count_sort_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_if),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // Shadow of the grouping state
    logic signed [VAL_W-1:0] grp_val [CAPACITY];
    int                      grp_cnt [CAPACITY];
    int                      obj_grp [CAPACITY];
    int                      n_obj;
    int                      n_grp;
    bit                      dropped;
    logic [TOL_W-1:0]        tol_reg;
    logic [OFS_W-1:0]        ofs_reg;

    t_node_result            node_q [$];

    int  cycles;
    int  errors;
    int  send_idle_pct;
    int  recv_stall_pct;
    int  hold_until;

    // Clock
    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // Cycle counter and run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Receiver: random stalls, plus long hold-off windows
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else if (cycles < hold_until) begin
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Result checker
    always @(posedge i_clk) begin
        t_node_result got, want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            got = '{out_if.object_node, out_if.node_value, out_if.node_count,
                    out_if.node_valid, out_if.overflow, out_if.last_result};
            if (node_q.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: node=%0d value=%0h", got.node, got.value);
            end else begin
                want = node_q.pop_front();
                if (got !== want) begin
                    errors++;
                    if (errors <= 10)
                        $display({"mismatch: exp node=%0d val=%0h cnt=%0d v=%0b ovf=%0b ",
                                  "last=%0b / got node=%0d val=%0h cnt=%0d v=%0b ovf=%0b last=%0b"},
                                 want.node, want.value, want.count, want.valid, want.ovf,
                                 want.last, got.node, got.value, got.count, got.valid,
                                 got.ovf, got.last);
                end
            end
        end
    end

    // Group one sample into the shadow state
    function automatic void absorb_sample(logic signed [VAL_W-1:0] s);
        longint diff;
        if (n_obj >= CAPACITY) begin
            dropped = 1'b1;
            return;
        end
        for (int i = 0; i < n_grp; i++) begin
            diff = longint'(grp_val[i]) - longint'(s);
            if (diff < 0) diff = -diff;
            if (diff < longint'({1'b0, tol_reg})) begin
                grp_cnt[i]++;
                obj_grp[n_obj++] = i;
                return;
            end
        end
        grp_val[n_grp]   = s;
        grp_cnt[n_grp]   = 1;
        obj_grp[n_obj++] = n_grp;
        n_grp++;
    endfunction

    // Rank the groups ascending (stable) and queue one result per object
    function automatic void close_column();
        int                      rank [CAPACITY];
        logic signed [VAL_W-1:0] s_val [CAPACITY];
        int                      s_cnt [CAPACITY];
        t_node_result            r;
        for (int i = 0; i < n_grp; i++) begin
            rank[i] = 0;
            for (int j = 0; j < n_grp; j++)
                if (grp_val[j] < grp_val[i] || (grp_val[j] == grp_val[i] && j < i))
                    rank[i]++;
            s_val[rank[i]] = grp_val[i];
            s_cnt[rank[i]] = grp_cnt[i];
        end
        for (int i = 0; i < n_obj; i++) begin
            r.node  = NODE_W'(rank[obj_grp[i]] + ofs_reg);
            r.valid = (i < n_grp);
            r.value = r.valid ? s_val[i] : '0;
            r.count = r.valid ? CNT_W'(s_cnt[i]) : '0;
            r.ovf   = dropped;
            r.last  = (i + 1 == n_obj);
            node_q.push_back(r);
        end
        n_obj   = 0;
        n_grp   = 0;
        dropped = 1'b0;
    endfunction

    // Send one item, waiting for acceptance; valid stays high for the next item
    task automatic send_sample(logic signed [VAL_W-1:0] s, bit last);
        while ($urandom_range(99) < send_idle_pct) begin
            in_if.valid <= 1'b0;
            in_if.sample <= $urandom;
            @(posedge i_clk);
        end
        in_if.valid       <= 1'b1;
        in_if.sample      <= s;
        in_if.last_sample <= last;
        do @(posedge i_clk); while (!in_if.ready);
        absorb_sample(s);
        if (last) close_column();
    endtask

    task automatic stop_sending();
        in_if.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Wait until every expected result is back, then let the block settle
    task automatic drain();
        stop_sending();
        wait (node_q.size() == 0);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= data;
        do @(posedge i_clk); while (!cfg_if.ready);
        if (idx == REG_TOLERANCE) tol_reg = data[TOL_W-1:0];
        else                      ofs_reg = data[OFS_W-1:0];
        cfg_if.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Column of clustered samples with random content; some fully random
    task automatic send_column(int len);
        logic signed [VAL_W-1:0] centers [4];
        int                      jit;
        logic signed [VAL_W-1:0] s;
        foreach (centers[k]) centers[k] = $urandom;
        jit = (tol_reg > 31'h0100_0000) ? 32'h0100_0000 : int'(tol_reg) + 2;
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(9) < 7)
                s = centers[$urandom_range(3)] + $signed($urandom_range(0, 2 * jit)) - jit;
            else
                s = $urandom;
            send_sample(s, i == len - 1);
        end
    endtask

    task automatic randomize_regs();
        logic [31:0] top;
        top = 32'($urandom_range(1)) << 31;
        case ($urandom_range(3))
            0: write_reg(REG_TOLERANCE, top);
            1: write_reg(REG_TOLERANCE, top | 32'h7FFF_FFFF);
            2: write_reg(REG_TOLERANCE, $urandom);
            default: write_reg(REG_TOLERANCE, top | $urandom_range(1, 32'h0003_0000));
        endcase
        case ($urandom_range(2))
            0: write_reg(REG_INDEX_OFFSET, {16'($urandom_range(16'hFFFF)), 16'h0});
            1: write_reg(REG_INDEX_OFFSET, {16'($urandom_range(16'hFFFF)), 16'hFFFF});
            default: write_reg(REG_INDEX_OFFSET, $urandom);
        endcase
    endtask

    // Reset values: zero tolerance, so equal samples still form separate groups
    task automatic test_reset_defaults();
        send_sample(32'sh8000_0000, 1'b0);
        send_sample(32'sh7FFF_FFFF, 1'b0);
        send_sample(32'sh0, 1'b0);
        send_sample(-32'sd1, 1'b0);
        send_sample(32'sh0, 1'b1);
        drain();
    endtask

    // Extreme fields and register values
    task automatic test_directed_extremes();
        write_reg(REG_TOLERANCE, 32'hFFFF_FFFF);
        write_reg(REG_INDEX_OFFSET, 32'h0000_FFFF);
        send_sample(32'sh7FFF_FFFF, 1'b0);
        send_sample(32'sh8000_0000, 1'b0);
        send_sample(32'sh0, 1'b0);
        send_sample(32'sh1, 1'b0);
        send_sample(32'sh8000_0001, 1'b1);
        send_sample(32'sh1234_5678, 1'b1);    // single-item column
        drain();
        write_reg(REG_TOLERANCE, 32'h0001_0000);
        write_reg(REG_INDEX_OFFSET, 32'h0);
        send_sample(32'sh0002_0000, 1'b0);
        send_sample(32'sh0001_0000, 1'b0);    // exactly on tolerance: no match
        send_sample(32'sh0001_8000, 1'b0);    // joins the earliest close group
        send_sample(32'sh0001_0000, 1'b0);
        send_sample(-32'sh0001_0000, 1'b1);
        drain();
    endtask

    // Overflow: past capacity, including a dropped item that closes the column
    task automatic test_capacity_overflow();
        write_reg(REG_TOLERANCE, 32'h0000_0100);
        send_column(CAPACITY);
        send_column(CAPACITY + 1);
        for (int i = 0; i < CAPACITY + 3; i++)
            send_sample($urandom, i == CAPACITY + 2);
        drain();
    endtask

    // Receiver holds off while columns keep arriving; then the sender waits
    task automatic test_backpressure();
        send_column(6);
        hold_until = cycles + 600;
        send_column(12);
        send_column(8);
        drain();
    endtask

    task automatic test_random(int items, int idle_pct, int stall_pct);
        int sent, len;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        sent = 0;
        while (sent < items) begin
            if ($urandom_range(2) == 0) begin
                drain();
                randomize_regs();
            end
            len = ($urandom_range(11) == 0) ? $urandom_range(CAPACITY - 4, CAPACITY + 4)
                                           : $urandom_range(1, 12);
            send_column(len);
            sent += len;
        end
        drain();
    endtask

    initial begin
        cycles = 0;
        errors = 0;
        hold_until = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        n_obj = 0;
        n_grp = 0;
        dropped = 1'b0;
        tol_reg = '0;
        ofs_reg = '0;
        i_rst_n = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.index = '0;
        cfg_if.data = '0;
        in_if.valid = 1'b0;
        in_if.sample = '0;
        in_if.last_sample = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_directed_extremes();
        test_capacity_overflow();
        test_backpressure();
        test_random(45, 0, 0);
        test_random(45, 68, 0);
        test_random(45, 0, 68);
        test_random(45, 13, 13);

        wait (node_q.size() == 0);
        repeat (SETTLE) @(posedge i_clk);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
